// File: hw/rtl/lsc_pkg.sv
// Shared constants for the line segment clipper: register indexes and reset values.
package lsc_pkg;

   typedef enum logic [1:0] {
      CSR_CLIP_X_MIN = 2'd0,
      CSR_CLIP_X_MAX = 2'd1,
      CSR_CLIP_Y_MIN = 2'd2,
      CSR_CLIP_Y_MAX = 2'd3
   } csr_index_type;

   localparam int CSR_INDEX_WIDTH = 2;

   localparam int CLIP_X_MIN_RESET = 0;
   localparam int CLIP_X_MAX_RESET = 1023;
   localparam int CLIP_Y_MIN_RESET = 0;
   localparam int CLIP_Y_MAX_RESET = 767;

endpackage

// File: hw/rtl/lsc_req_if.sv
// Segment request channel: valid/ready with the two endpoints.
interface lsc_req_if #(
   parameter int COORD_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// File: hw/rtl/lsc_rsp_if.sv
// Clip result channel: valid/ready with the visible flag and clipped endpoints.
interface lsc_rsp_if #(
   parameter int COORD_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic                          visible;
   logic signed [COORD_WIDTH-1:0] clipped_start_x;
   logic signed [COORD_WIDTH-1:0] clipped_start_y;
   logic signed [COORD_WIDTH-1:0] clipped_end_x;
   logic signed [COORD_WIDTH-1:0] clipped_end_y;

   modport source (output valid, visible, clipped_start_x, clipped_start_y,
                   clipped_end_x, clipped_end_y, input ready);
   modport sink   (input valid, visible, clipped_start_x, clipped_start_y,
                   clipped_end_x, clipped_end_y, output ready);
endinterface

// File: hw/rtl/line_segment_clipper_unit.sv
// Line segment clipper top level: pipelined Liang-Barsky clip against a register-held rectangle.
//
// Takes one segment transaction per cycle while the result side is not stalled and returns
// one result transaction per segment, in order. The depth is set by the parameter divider,
// which resolves one quotient bit per stage for the entry and exit parameters t0 and t1; the
// other stages form edge differences, pick the entering and exiting edge by cross-multiplying
// fractions, check t0 <= t1, scale the deltas by the quantised parameters and clamp into the
// rectangle. Every stage holds its own valid bit and only moves when the next one can take it,
// so bubbles are squeezed out under back-pressure and the last stage doubles as the output
// register. Clip rectangle registers are written through the csr_ port and must only change
// while no transaction is in flight. Invisible segments return all-zero coordinates.
module line_segment_clipper_unit #(
   parameter int COORD_WIDTH         = 16,
   parameter int PARAM_FRACTION_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   lsc_req_if.sink                              req_chan,
   lsc_rsp_if.source                            rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [lsc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [COORD_WIDTH-1:0]               csr_write_data
);

   localparam int CW     = COORD_WIDTH;
   localparam int F      = PARAM_FRACTION_BITS;
   localparam int TW     = F + 1;          // Q1.F parameter
   localparam int PW     = TW + CW;        // parameter times delta magnitude
   localparam int DV0    = 5;              // divider entry stage
   localparam int T_IX   = DV0 + TW + 1;
   localparam int M_IX   = T_IX + 1;
   localparam int O_IX   = M_IX + 1;
   localparam int OUT_IX = O_IX + 1;
   localparam int NS     = OUT_IX + 1;

   localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

   // ------------------------------------------------------------------
   // Stage payload types
   // ------------------------------------------------------------------
   typedef struct packed {
      logic                 ok;
      logic signed [CW-1:0] x0;
      logic signed [CW-1:0] y0;
      logic                 sx;      // delta negative
      logic                 sy;
      logic [CW-1:0]        adx;     // delta magnitude
      logic [CW-1:0]        ady;
   } carry_type;

   typedef struct packed {
      logic                 fail;
      logic [CW-1:0]        en_n;
      logic [CW-1:0]        en_d;
      logic [CW-1:0]        ex_n;
      logic [CW-1:0]        ex_d;
   } axis_type;

   typedef struct packed {
      logic signed [CW-1:0] x0;
      logic signed [CW-1:0] y0;
      logic signed [CW:0]   dx;
      logic signed [CW:0]   dy;
      logic signed [CW:0]   qxl;
      logic signed [CW:0]   qxh;
      logic signed [CW:0]   qyl;
      logic signed [CW:0]   qyh;
   } s1_type;

   typedef struct packed {
      carry_type c;
      axis_type  ax;
      axis_type  ay;
   } s2_type;

   typedef struct packed {
      carry_type       c;
      axis_type        ax;
      axis_type        ay;
      logic [2*CW-1:0] pe_a;
      logic [2*CW-1:0] pe_b;
      logic [2*CW-1:0] px_a;
      logic [2*CW-1:0] px_b;
   } s3_type;

   typedef struct packed {
      carry_type     c;
      logic [CW-1:0] n0;
      logic [CW-1:0] d0;
      logic [CW-1:0] n1;
      logic [CW-1:0] d1;
   } s4_type;

   typedef struct packed {
      carry_type       c;
      logic [CW-1:0]   n0;
      logic [CW-1:0]   d0;
      logic [CW-1:0]   n1;
      logic [CW-1:0]   d1;
      logic [2*CW-1:0] m0;
      logic [2*CW-1:0] m1;
   } s5_type;

   typedef struct packed {
      carry_type     c;
      logic [CW-1:0] d0;
      logic [CW-1:0] d1;
      logic [CW-1:0] r0;
      logic [CW-1:0] r1;
      logic [TW-1:0] q0;
      logic [TW-1:0] q1;
      logic          full0;
      logic          full1;
   } dv_type;

   typedef struct packed {
      carry_type     c;
      logic [TW-1:0] t0;
      logic [TW-1:0] t1;
   } t_type;

   typedef struct packed {
      carry_type     c;
      logic [PW-1:0] p_sx;
      logic [PW-1:0] p_sy;
      logic [PW-1:0] p_ex;
      logic [PW-1:0] p_ey;
   } m_type;

   typedef struct packed {
      carry_type   c;
      logic [CW:0] o_sx;
      logic [CW:0] o_sy;
      logic [CW:0] o_ex;
      logic [CW:0] o_ey;
   } o_type;

   typedef struct packed {
      logic                 visible;
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
      logic signed [CW-1:0] ex;
      logic signed [CW-1:0] ey;
   } out_type;

   // ------------------------------------------------------------------
   // Helpers
   // ------------------------------------------------------------------
   // Entering/exiting candidate fractions for one axis; no entry is 0/1, no exit is 1/1.
   function automatic axis_type axis_cands(input logic signed [CW:0] dd,
                                           input logic signed [CW:0] ql,
                                           input logic signed [CW:0] qh);
      axis_type    a;
      logic [CW:0] mag;
      logic [CW:0] nl;
      logic [CW:0] nh;
      a.fail = 1'b0;
      a.en_n = '0;
      a.en_d = CW'(1);
      a.ex_n = CW'(1);
      a.ex_d = CW'(1);
      mag = dd[CW] ? $unsigned(-dd) : $unsigned(dd);
      nl  = $unsigned(-ql);
      nh  = $unsigned(-qh);
      if (dd == '0) begin
         a.fail = ql[CW] | qh[CW];
      end else if (!dd[CW]) begin
         if (ql[CW]) begin
            if (nl > mag) begin
               a.fail = 1'b1;
            end else begin
               a.en_n = nl[CW-1:0];
               a.en_d = mag[CW-1:0];
            end
         end
         if (qh[CW]) begin
            a.fail = 1'b1;
         end else if ($unsigned(qh) < mag) begin
            a.ex_n = qh[CW-1:0];
            a.ex_d = mag[CW-1:0];
         end
      end else begin
         if (ql[CW]) begin
            a.fail = 1'b1;
         end else if ($unsigned(ql) < mag) begin
            a.ex_n = ql[CW-1:0];
            a.ex_d = mag[CW-1:0];
         end
         if (qh[CW]) begin
            if (nh > mag) begin
               a.fail = 1'b1;
            end else begin
               a.en_n = nh[CW-1:0];
               a.en_d = mag[CW-1:0];
            end
         end
      end
      return a;
   endfunction

   function automatic logic signed [CW-1:0] place(input logic signed [CW-1:0] p0,
                                                  input logic                 neg,
                                                  input logic [CW:0]          off,
                                                  input logic signed [CW-1:0] lo,
                                                  input logic signed [CW-1:0] hi);
      logic signed [CW+1:0] v;
      logic signed [CW+1:0] o;
      o = $signed({1'b0, off});
      v = neg ? (CW+2)'(p0) - o : (CW+2)'(p0) + o;
      if (v < (CW+2)'(lo)) v = (CW+2)'(lo);
      if (v > (CW+2)'(hi)) v = (CW+2)'(hi);
      return v[CW-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Clip rectangle registers
   // ------------------------------------------------------------------
   logic signed [CW-1:0] clip_x_min_ff, clip_x_min_in;
   logic signed [CW-1:0] clip_x_max_ff, clip_x_max_in;
   logic signed [CW-1:0] clip_y_min_ff, clip_y_min_in;
   logic signed [CW-1:0] clip_y_max_ff, clip_y_max_in;

   always_comb begin
      clip_x_min_in = clip_x_min_ff;
      clip_x_max_in = clip_x_max_ff;
      clip_y_min_in = clip_y_min_ff;
      clip_y_max_in = clip_y_max_ff;
      if (csr_write_enable) begin
         case (csr_index)
            lsc_pkg::CSR_CLIP_X_MIN: clip_x_min_in = csr_write_data;
            lsc_pkg::CSR_CLIP_X_MAX: clip_x_max_in = csr_write_data;
            lsc_pkg::CSR_CLIP_Y_MIN: clip_y_min_in = csr_write_data;
            lsc_pkg::CSR_CLIP_Y_MAX: clip_y_max_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_x_min_ff <= CW'(lsc_pkg::CLIP_X_MIN_RESET);
         clip_x_max_ff <= CW'(lsc_pkg::CLIP_X_MAX_RESET);
         clip_y_min_ff <= CW'(lsc_pkg::CLIP_Y_MIN_RESET);
         clip_y_max_ff <= CW'(lsc_pkg::CLIP_Y_MAX_RESET);
      end else begin
         clip_x_min_ff <= clip_x_min_in;
         clip_x_max_ff <= clip_x_max_in;
         clip_y_min_ff <= clip_y_min_in;
         clip_y_max_ff <= clip_y_max_in;
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control: a stage loads when it is empty or drains onward
   // ------------------------------------------------------------------
   logic [NS-1:0] valid_ff, valid_in;
   logic [NS-1:0] stage_en;

   always_comb begin
      stage_en[NS-1] = !valid_ff[NS-1] || rsp_chan.ready;
      for (int i = NS - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (stage_en[0]) valid_in[0] = req_chan.valid;
      for (int i = 1; i < NS; i++) begin
         if (stage_en[i]) valid_in[i] = valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_chan.ready = stage_en[0];

   // ------------------------------------------------------------------
   // Datapath
   // ------------------------------------------------------------------
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   s4_type  s4_ff, s4_in;
   s5_type  s5_ff, s5_in;
   dv_type  dv_ff [TW+1];
   dv_type  dv_in [TW+1];
   t_type   t_ff, t_in;
   m_type   m_ff, m_in;
   o_type   o_ff, o_in;
   out_type out_ff, out_in;

   // Edge distances and deltas
   always_comb begin
      s1_in.x0  = req_chan.start_x;
      s1_in.y0  = req_chan.start_y;
      s1_in.dx  = (CW+1)'(req_chan.end_x) - (CW+1)'(req_chan.start_x);
      s1_in.dy  = (CW+1)'(req_chan.end_y) - (CW+1)'(req_chan.start_y);
      s1_in.qxl = (CW+1)'(req_chan.start_x) - (CW+1)'(clip_x_min_ff);
      s1_in.qxh = (CW+1)'(clip_x_max_ff) - (CW+1)'(req_chan.start_x);
      s1_in.qyl = (CW+1)'(req_chan.start_y) - (CW+1)'(clip_y_min_ff);
      s1_in.qyh = (CW+1)'(clip_y_max_ff) - (CW+1)'(req_chan.start_y);
   end

   // Per-axis candidates
   always_comb begin
      logic [CW:0] mx;
      logic [CW:0] my;
      mx = s1_ff.dx[CW] ? $unsigned(-s1_ff.dx) : $unsigned(s1_ff.dx);
      my = s1_ff.dy[CW] ? $unsigned(-s1_ff.dy) : $unsigned(s1_ff.dy);
      s2_in.ax    = axis_cands(s1_ff.dx, s1_ff.qxl, s1_ff.qxh);
      s2_in.ay    = axis_cands(s1_ff.dy, s1_ff.qyl, s1_ff.qyh);
      s2_in.c.ok  = !s2_in.ax.fail && !s2_in.ay.fail;
      s2_in.c.x0  = s1_ff.x0;
      s2_in.c.y0  = s1_ff.y0;
      s2_in.c.sx  = s1_ff.dx[CW];
      s2_in.c.sy  = s1_ff.dy[CW];
      s2_in.c.adx = mx[CW-1:0];
      s2_in.c.ady = my[CW-1:0];
   end

   // Cross products to rank x against y candidates
   always_comb begin
      s3_in.c    = s2_ff.c;
      s3_in.ax   = s2_ff.ax;
      s3_in.ay   = s2_ff.ay;
      s3_in.pe_a = (2*CW)'(s2_ff.ax.en_n) * (2*CW)'(s2_ff.ay.en_d);
      s3_in.pe_b = (2*CW)'(s2_ff.ay.en_n) * (2*CW)'(s2_ff.ax.en_d);
      s3_in.px_a = (2*CW)'(s2_ff.ax.ex_n) * (2*CW)'(s2_ff.ay.ex_d);
      s3_in.px_b = (2*CW)'(s2_ff.ay.ex_n) * (2*CW)'(s2_ff.ax.ex_d);
   end

   // t0 = latest entry, t1 = earliest exit
   always_comb begin
      s4_in.c = s3_ff.c;
      if (s3_ff.pe_a > s3_ff.pe_b) begin
         s4_in.n0 = s3_ff.ax.en_n;
         s4_in.d0 = s3_ff.ax.en_d;
      end else begin
         s4_in.n0 = s3_ff.ay.en_n;
         s4_in.d0 = s3_ff.ay.en_d;
      end
      if (s3_ff.px_a > s3_ff.px_b) begin
         s4_in.n1 = s3_ff.ay.ex_n;
         s4_in.d1 = s3_ff.ay.ex_d;
      end else begin
         s4_in.n1 = s3_ff.ax.ex_n;
         s4_in.d1 = s3_ff.ax.ex_d;
      end
   end

   always_comb begin
      s5_in.c  = s4_ff.c;
      s5_in.n0 = s4_ff.n0;
      s5_in.d0 = s4_ff.d0;
      s5_in.n1 = s4_ff.n1;
      s5_in.d1 = s4_ff.d1;
      s5_in.m0 = (2*CW)'(s4_ff.n0) * (2*CW)'(s4_ff.d1);
      s5_in.m1 = (2*CW)'(s4_ff.n1) * (2*CW)'(s4_ff.d0);
   end

   // Divider entry: reject empty interval, seed remainders
   always_comb begin
      dv_in[0].c     = s5_ff.c;
      dv_in[0].c.ok  = s5_ff.c.ok && !(s5_ff.m0 > s5_ff.m1);
      dv_in[0].d0    = s5_ff.d0;
      dv_in[0].d1    = s5_ff.d1;
      dv_in[0].r0    = s5_ff.n0;
      dv_in[0].r1    = s5_ff.n1;
      dv_in[0].q0    = '0;
      dv_in[0].q1    = '0;
      dv_in[0].full0 = s5_ff.n0 >= s5_ff.d0;
      dv_in[0].full1 = s5_ff.n1 >= s5_ff.d1;
   end

   // One restoring quotient bit per stage
   for (genvar k = 1; k <= TW; k++) begin : g_div
      always_comb begin
         logic [CW:0] a0;
         logic [CW:0] a1;
         logic        g0;
         logic        g1;
         a0 = {dv_ff[k-1].r0, 1'b0};
         a1 = {dv_ff[k-1].r1, 1'b0};
         g0 = a0 >= {1'b0, dv_ff[k-1].d0};
         g1 = a1 >= {1'b0, dv_ff[k-1].d1};
         dv_in[k]    = dv_ff[k-1];
         dv_in[k].r0 = g0 ? CW'(a0 - {1'b0, dv_ff[k-1].d0}) : a0[CW-1:0];
         dv_in[k].r1 = g1 ? CW'(a1 - {1'b0, dv_ff[k-1].d1}) : a1[CW-1:0];
         dv_in[k].q0 = {dv_ff[k-1].q0[TW-2:0], g0};
         dv_in[k].q1 = {dv_ff[k-1].q1[TW-2:0], g1};
      end
   end

   // Round the extra quotient bit away: Q1.F, half up
   always_comb begin
      logic [TW:0] r0;
      logic [TW:0] r1;
      r0 = ({1'b0, dv_ff[TW].q0} + (TW+1)'(1)) >> 1;
      r1 = ({1'b0, dv_ff[TW].q1} + (TW+1)'(1)) >> 1;
      t_in.c  = dv_ff[TW].c;
      t_in.t0 = dv_ff[TW].full0 ? (TW'(1) << F) : r0[TW-1:0];
      t_in.t1 = dv_ff[TW].full1 ? (TW'(1) << F) : r1[TW-1:0];
   end

   always_comb begin
      m_in.c    = t_ff.c;
      m_in.p_sx = PW'(t_ff.t0) * PW'(t_ff.c.adx);
      m_in.p_sy = PW'(t_ff.t0) * PW'(t_ff.c.ady);
      m_in.p_ex = PW'(t_ff.t1) * PW'(t_ff.c.adx);
      m_in.p_ey = PW'(t_ff.t1) * PW'(t_ff.c.ady);
   end

   // Offsets rounded to nearest, halves away from zero on the magnitude
   always_comb begin
      logic [PW-1:0] a;
      logic [PW-1:0] b;
      logic [PW-1:0] c;
      logic [PW-1:0] d;
      a = m_ff.p_sx + HALF;
      b = m_ff.p_sy + HALF;
      c = m_ff.p_ex + HALF;
      d = m_ff.p_ey + HALF;
      o_in.c    = m_ff.c;
      o_in.o_sx = a[F +: CW+1];
      o_in.o_sy = b[F +: CW+1];
      o_in.o_ex = c[F +: CW+1];
      o_in.o_ey = d[F +: CW+1];
   end

   // Endpoints, clamp into rectangle, zero when hidden
   always_comb begin
      out_in.visible = o_ff.c.ok;
      out_in.sx      = '0;
      out_in.sy      = '0;
      out_in.ex      = '0;
      out_in.ey      = '0;
      if (o_ff.c.ok) begin
         out_in.sx = place(o_ff.c.x0, o_ff.c.sx, o_ff.o_sx, clip_x_min_ff, clip_x_max_ff);
         out_in.sy = place(o_ff.c.y0, o_ff.c.sy, o_ff.o_sy, clip_y_min_ff, clip_y_max_ff);
         out_in.ex = place(o_ff.c.x0, o_ff.c.sx, o_ff.o_ex, clip_x_min_ff, clip_x_max_ff);
         out_in.ey = place(o_ff.c.y0, o_ff.c.sy, o_ff.o_ey, clip_y_min_ff, clip_y_max_ff);
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (stage_en[0])      s1_ff  <= s1_in;
      if (stage_en[1])      s2_ff  <= s2_in;
      if (stage_en[2])      s3_ff  <= s3_in;
      if (stage_en[3])      s4_ff  <= s4_in;
      if (stage_en[4])      s5_ff  <= s5_in;
      if (stage_en[T_IX])   t_ff   <= t_in;
      if (stage_en[M_IX])   m_ff   <= m_in;
      if (stage_en[O_IX])   o_ff   <= o_in;
      if (stage_en[OUT_IX]) out_ff <= out_in;
   end

   for (genvar k = 0; k <= TW; k++) begin : g_dv_reg
      always_ff @(posedge clock) begin
         if (stage_en[DV0+k]) dv_ff[k] <= dv_in[k];
      end
   end

   assign rsp_chan.valid           = valid_ff[OUT_IX];
   assign rsp_chan.visible         = out_ff.visible;
   assign rsp_chan.clipped_start_x = out_ff.sx;
   assign rsp_chan.clipped_start_y = out_ff.sy;
   assign rsp_chan.clipped_end_x   = out_ff.ex;
   assign rsp_chan.clipped_end_y   = out_ff.ey;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.visible |->
         out_ff.sx == '0 && out_ff.sy == '0 && out_ff.ex == '0 && out_ff.ey == '0)
      else $error("hidden segment with non-zero coordinates");

   a_param_order: assert property (@(posedge clock) disable iff (reset)
      valid_ff[T_IX] && t_ff.c.ok |-> t_ff.t0 <= t_ff.t1)
      else $error("entry parameter beyond exit parameter");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> valid_ff[0])
      else $error("accepted transaction not captured");

endmodule
